@@ rtl/odr_pkg.sv @@
// shared constants and helpers for the ordered dither rank block
`default_nettype none
package odr_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned RANK_W     = 12;
  localparam int unsigned DRIFT_BITS = 8;
  localparam int unsigned HASH_W     = 32;
  // only the low bits of the second product reach the two cell bits
  localparam int unsigned HASH_LO_W  = 18;

  localparam logic [31:0] HASH_MUL_A    = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B    = 32'h846ca68b;
  localparam logic [17:0] HASH_MUL_B_LO = HASH_MUL_B[17:0];
  localparam logic [31:0] GOLDEN        = 32'h9e3779b9;

  // pattern modes; the unused code falls back to plain
  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_SCRAMBLE = 2'd1;
  localparam logic [1:0] MODE_DRIFT    = 2'd2;

  // register index on the configuration port
  localparam logic REG_PATTERN_MODE = 1'b0;

  // rotate a 32-bit word left
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
    logic [4:0] s;
    s = 5'(r);
    rotl32 = (s == 5'd0) ? v : ((v << s) | (v >> (6'd32 - {1'b0, s})));
  endfunction

endpackage
`default_nettype wire

@@ rtl/ordered_dither_rank_top.sv @@
// ordered dither rank: pixel coordinate to 12-bit threshold rank, pipelined
//
// Usage:
//   in_tdata carries one pixel coordinate per transfer; out_tdata returns the
//   dither threshold rank for it, in the same order, one result per input.
//   pattern_mode is written over the cfg_ APB port at byte address 0 while
//   the block is idle; it selects plain, hash scrambled or tile drift ranks.
// Pipeline and throughput:
//   four register stages (hash pre-mix, first hash multiply, second hash
//   multiply, output register). One transfer per cycle sustained while
//   out_tready stays high; the hash multipliers are one per level in each
//   multiply stage and set the stage depth.
// Reset:
//   rst_n clears all stage valid bits and sets pattern_mode to plain.
// Stall:
//   each full stage holds while the next one is full and stalled; in_tready stays
//   high as long as any stage bubble can absorb a new transfer.
`default_nettype none
module ordered_dither_rank_top
  import odr_pkg::*;
#(
  parameter int unsigned LEVELS = 6
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [15:0] x_coord, [31:16] y_coord
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [11:0] rank, [15:12] zero
  // configuration port
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration register
  logic [1:0] mode_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_PATTERN_MODE)) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_PATTERN_MODE) begin
      cfg_prdata = {30'd0, mode_r};
    end
  end

  // stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: plain and drift rank, hash input with first fold
  logic [COORD_W-1:0] x_in, y_in;
  logic [RANK_W-1:0]  prank_nxt;
  logic [HASH_W-1:0]  hv_nxt [LEVELS];
  logic [DRIFT_BITS-1:0] drift_par;
  logic [HASH_W-1:0]  drift_word;

  assign x_in = in_tdata[15:0];
  assign y_in = in_tdata[31:16];
  assign drift_word = {COORD_W'(y_in >> LEVELS), COORD_W'(x_in >> LEVELS)};

  for (genvar j = 0; j < LEVELS; j++) begin : g_hash_in
    localparam logic [31:0] SALT = 32'(GOLDEN * j);
    logic [HASH_W-1:0] h;
    assign h = {COORD_W'(y_in >> (j + 1)), COORD_W'(x_in >> (j + 1))} ^ SALT;
    assign hv_nxt[j] = h ^ (h >> 16);
  end

  for (genvar k = 0; k < DRIFT_BITS; k++) begin : g_drift
    localparam logic [31:0] DMASK = rotl32(GOLDEN, 3 * k);
    assign drift_par[k] = ^(drift_word & DMASK);
  end

  always_comb begin
    logic [RANK_W-1:0] r;
    logic twist;
    logic xb, yb;
    r = '0;
    twist = 1'b0;
    for (int unsigned j = 0; j < LEVELS; j++) begin
      xb = x_in[j];
      yb = y_in[j];
      r = {r[RANK_W-3:0], xb ^ yb, yb ^ twist};
      twist = twist ^ xb ^ yb;
    end
    if (mode_r == MODE_DRIFT) begin
      r = r ^ RANK_W'(drift_par);
    end
    prank_nxt = r;
  end

  logic [HASH_W-1:0] hv_r [LEVELS];
  logic [RANK_W-1:0] prank1_r;
  logic [LEVELS-1:0] xl1_r, yl1_r;
  logic              scr1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      hv_r     <= hv_nxt;
      prank1_r <= prank_nxt;
      xl1_r    <= x_in[LEVELS-1:0];
      yl1_r    <= y_in[LEVELS-1:0];
      scr1_r   <= (mode_r == MODE_SCRAMBLE);
    end
  end

  // stage 2: first hash multiply, one per level
  logic [HASH_W-1:0] u_r [LEVELS];
  logic [RANK_W-1:0] prank2_r;
  logic [LEVELS-1:0] xl2_r, yl2_r;
  logic              scr2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int unsigned j = 0; j < LEVELS; j++) begin
        u_r[j] <= hv_r[j] * HASH_MUL_A;
      end
      prank2_r <= prank1_r;
      xl2_r    <= xl1_r;
      yl2_r    <= yl1_r;
      scr2_r   <= scr1_r;
    end
  end

  // stage 3: second fold and low part of the second multiply
  logic [HASH_LO_W-1:0] p_r [LEVELS];
  logic [RANK_W-1:0]    prank3_r;
  logic [LEVELS-1:0]    xl3_r, yl3_r;
  logic                 scr3_r;
  logic [HASH_W-1:0]    w_fold [LEVELS];

  for (genvar j = 0; j < LEVELS; j++) begin : g_fold
    assign w_fold[j] = u_r[j] ^ (u_r[j] >> 15);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int unsigned j = 0; j < LEVELS; j++) begin
        p_r[j] <= w_fold[j][HASH_LO_W-1:0] * HASH_MUL_B_LO;
      end
      prank3_r <= prank2_r;
      xl3_r    <= xl2_r;
      yl3_r    <= yl2_r;
      scr3_r   <= scr2_r;
    end
  end

  // stage 4: final fold, scrambled rank and output select
  logic [RANK_W-1:0] rank_nxt;
  logic [RANK_W-1:0] rank_r;

  always_comb begin
    logic [RANK_W-1:0] r;
    logic c0, c1;
    r = '0;
    for (int unsigned j = 0; j < LEVELS; j++) begin
      c0 = p_r[j][0] ^ p_r[j][16];
      c1 = p_r[j][1] ^ p_r[j][17];
      r = {r[RANK_W-3:0], xl3_r[j] ^ yl3_r[j] ^ c0, yl3_r[j] ^ c1};
    end
    rank_nxt = scr3_r ? r : prank3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      rank_r <= rank_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'd0, rank_r};

  // checks on the pipeline control
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted transfer did not enter stage 1");

  a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r || !v2_r || !v3_r || !v4_r) |-> in_tready)
    else $error("input stalled although a stage was empty");

  a_stage3_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && v4_r && !out_tready) |=> (v3_r && v4_r))
    else $error("stalled item lost in stage 3");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !v4_r) |=> v4_r)
    else $error("stage 3 item did not advance into empty output");

endmodule
`default_nettype wire
